// ===== hdl/touch_gesture_classifier_assert.svh =====
// Assertion macros for the touch gesture classifier.
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define TGC_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("touch gesture classifier check failed");
`define TGC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("touch gesture classifier check failed");
`else
`define TGC_ASSERT_ALWAYS(lbl, cond)
`define TGC_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== hdl/tgc_pkg.sv =====
package tgc_pkg;

	typedef enum logic [1:0] {
		MODE_PRESS   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_LOST    = 2'd2,
		MODE_TICK    = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		G_NONE    = 4'd0,
		G_LEFT    = 4'd1,
		G_RIGHT   = 4'd2,
		G_UP      = 4'd3,
		G_DOWN    = 4'd4,
		G_DRAG    = 4'd5,
		G_LONG    = 4'd6,
		G_TAP     = 4'd7,
		G_BLOCKED = 4'd8
	} gesture_t;

	typedef enum logic [2:0] {
		CFG_SWIPE_THRESHOLD = 3'd0,
		CFG_LONG_PRESS_MS   = 3'd1,
		CFG_EDGE_MARGIN     = 3'd2,
		CFG_CENTER_X        = 3'd3,
		CFG_CENTER_Y        = 3'd4,
		CFG_CENTER_BAND     = 3'd5,
		CFG_SCREEN_WIDTH    = 3'd6,
		CFG_SCREEN_HEIGHT   = 3'd7
	} cfg_idx_t;

	localparam logic [31:0] TAP_GAP_MS = 32'd350;
	localparam logic [31:0] IGNORE_MS = 32'd350;
	localparam int unsigned DRIFT_PX = 14;

	localparam logic [9:0]  RST_SWIPE_THRESHOLD = 10'd60;
	localparam logic [15:0] RST_LONG_PRESS_MS = 16'd600;
	localparam logic [9:0]  RST_EDGE_MARGIN = 10'd40;
	localparam logic [9:0]  RST_CENTER_X = 10'd180;
	localparam logic [9:0]  RST_CENTER_Y = 10'd180;
	localparam logic [9:0]  RST_CENTER_BAND = 10'd80;
	localparam logic [10:0] RST_SCREEN_WIDTH = 11'd360;
	localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd360;

endpackage

// ===== hdl/touch_gesture_classifier.sv =====
// Items pass the input register, then the result register. Throughput: one item
// per cycle unless out_stall holds; the input register feeds the state update and the
// result register in a single pass, so each item sees the state left by the one before.
// Reset: arst_n clears all gesture state, empties both registers and loads the
// configuration registers with their default values.
`include "touch_gesture_classifier_assert.svh"

module touch_gesture_classifier import tgc_pkg::*; #(
	parameter int COORD_BITS = 10,
	parameter int TAP_LIMIT = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [COORD_BITS-1:0] touch_x,
	input  logic [COORD_BITS-1:0] touch_y,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            gesture,
	output logic                  start_ok,
	output logic                  tap_done,
	output logic [3:0]            tap_total
);

	localparam int SW = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;
	localparam logic signed [SW-1:0] DRIFT_S = SW'(DRIFT_PX);
	localparam logic [3:0] TAP_MAX = 4'(TAP_LIMIT);

	logic [9:0]  swipe_th_q, edge_margin_q, center_x_q, center_y_q, center_band_q;
	logic [15:0] long_press_q;
	logic [10:0] screen_w_q, screen_h_q;

	logic                  touch_active_q, touch_handled_q, drift_q, armed_q;
	logic [COORD_BITS-1:0] press_x_q, press_y_q;
	logic [31:0]           press_time_q, ignore_until_q, last_tap_q, deadline_q;
	logic [3:0]            tap_cnt_q;

	logic                  valid_s1;
	mode_t                 mode_s1;
	logic [COORD_BITS-1:0] tx_s1, ty_s1;
	logic [31:0]           now_s1;

	logic     valid_s2, ok_s2, done_s2;
	gesture_t gesture_s2;
	logic [3:0] total_s2;

	logic s2_free, advance, accept;

	function automatic logic signed [SW-1:0] sabs(input logic signed [SW-1:0] v);
		return v[SW-1] ? -v : v;
	endfunction

	assign s2_free = !valid_s2 || !out_stall;
	assign advance = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_th_q <= RST_SWIPE_THRESHOLD;
			long_press_q <= RST_LONG_PRESS_MS;
			edge_margin_q <= RST_EDGE_MARGIN;
			center_x_q <= RST_CENTER_X;
			center_y_q <= RST_CENTER_Y;
			center_band_q <= RST_CENTER_BAND;
			screen_w_q <= RST_SCREEN_WIDTH;
			screen_h_q <= RST_SCREEN_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SWIPE_THRESHOLD: swipe_th_q <= cfg_data[9:0];
				CFG_LONG_PRESS_MS:   long_press_q <= cfg_data;
				CFG_EDGE_MARGIN:     edge_margin_q <= cfg_data[9:0];
				CFG_CENTER_X:        center_x_q <= cfg_data[9:0];
				CFG_CENTER_Y:        center_y_q <= cfg_data[9:0];
				CFG_CENTER_BAND:     center_band_q <= cfg_data[9:0];
				CFG_SCREEN_WIDTH:    screen_w_q <= cfg_data[10:0];
				CFG_SCREEN_HEIGHT:   screen_h_q <= cfg_data[10:0];
				default:             swipe_th_q <= swipe_th_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_t'(mode);
			tx_s1 <= touch_x;
			ty_s1 <= touch_y;
			now_s1 <= now_ms;
		end
	end

	logic signed [SW-1:0] sx, sy, tx, ty, dx, dy, adx, ady, th, em, band;
	logic signed [SW-1:0] cx, cy, sw, sh;
	logic        drifted, xe, ye, near_cx, near_cy, long_press, in_window;
	logic [31:0] dur, tick_gap;
	logic [3:0]  tap_base;
	gesture_t    dir;
	logic        dir_ok;

	assign sx = $signed({{(SW-COORD_BITS){1'b0}}, press_x_q});
	assign sy = $signed({{(SW-COORD_BITS){1'b0}}, press_y_q});
	assign tx = $signed({{(SW-COORD_BITS){1'b0}}, tx_s1});
	assign ty = $signed({{(SW-COORD_BITS){1'b0}}, ty_s1});
	assign th = $signed({{(SW-10){1'b0}}, swipe_th_q});
	assign em = $signed({{(SW-10){1'b0}}, edge_margin_q});
	assign band = $signed({{(SW-10){1'b0}}, center_band_q});
	assign cx = $signed({{(SW-10){1'b0}}, center_x_q});
	assign cy = $signed({{(SW-10){1'b0}}, center_y_q});
	assign sw = $signed({{(SW-11){1'b0}}, screen_w_q});
	assign sh = $signed({{(SW-11){1'b0}}, screen_h_q});

	assign dx = tx - sx;
	assign dy = ty - sy;
	assign adx = sabs(dx);
	assign ady = sabs(dy);
	assign drifted = (adx > DRIFT_S) || (ady > DRIFT_S);
	assign xe = adx >= th;
	assign ye = ady >= th;
	assign near_cx = sabs(sx - cx) <= band;
	assign near_cy = sabs(sy - cy) <= band;
	assign dur = now_s1 - press_time_q;
	assign tick_gap = now_s1 - deadline_q;
	assign long_press = dur >= {16'd0, long_press_q};
	assign in_window = (ignore_until_q != 32'd0) && ((now_s1 - ignore_until_q) >> 31) != 32'd0;
	assign tap_base = ((last_tap_q == 32'd0) || ((now_s1 - last_tap_q) > TAP_GAP_MS))
		? 4'd0 : tap_cnt_q;

	always_comb begin
		if (adx > ady) begin
			dir = dx[SW-1] ? G_LEFT : G_RIGHT;
		end else begin
			dir = dy[SW-1] ? G_UP : G_DOWN;
		end
		case (dir)
			G_UP:    dir_ok = (sy > sh - em) && near_cx;
			G_DOWN:  dir_ok = (sy < em) && near_cx;
			G_LEFT:  dir_ok = (sx > sw - em) && near_cy;
			default: dir_ok = (sx < em) && near_cy;
		endcase
	end

	logic                  n_active, n_handled, n_drift, n_armed;
	logic [COORD_BITS-1:0] n_px, n_py;
	logic [31:0]           n_ptime, n_ignore, n_last, n_deadline;
	logic [3:0]            n_cnt;
	gesture_t              gest_c;
	logic                  ok_c, done_c;
	logic [3:0]            total_c;

	always_comb begin
		n_active = touch_active_q;
		n_handled = touch_handled_q;
		n_drift = drift_q;
		n_armed = armed_q;
		n_px = press_x_q;
		n_py = press_y_q;
		n_ptime = press_time_q;
		n_ignore = ignore_until_q;
		n_last = last_tap_q;
		n_deadline = deadline_q;
		n_cnt = tap_cnt_q;
		gest_c = G_NONE;
		ok_c = 1'b0;
		done_c = 1'b0;
		total_c = 4'd0;
		case (mode_s1)
			MODE_PRESS: begin
				n_drift = 1'b0;
				n_active = 1'b1;
				n_handled = 1'b0;
				n_px = tx_s1;
				n_py = ty_s1;
				n_ptime = now_s1;
			end
			MODE_LOST: begin
				n_drift = 1'b1;
				n_handled = 1'b1;
				n_active = 1'b0;
			end
			MODE_RELEASE: begin
				n_drift = drift_q || drifted;
				n_active = 1'b0;
				n_handled = 1'b0;
				if (touch_active_q && !touch_handled_q) begin
					if (xe != ye) begin
						gest_c = dir;
						ok_c = dir_ok;
						n_ignore = now_s1 + IGNORE_MS;
					end else if (xe) begin
						gest_c = G_DRAG;
					end else if (long_press) begin
						gest_c = G_LONG;
					end else if (n_drift) begin
						gest_c = G_BLOCKED;
					end else if (in_window) begin
						gest_c = G_BLOCKED;
					end else begin
						n_ignore = 32'd0;
						n_last = now_s1;
						n_cnt = (tap_base < TAP_MAX) ? tap_base + 4'd1 : tap_base;
						n_deadline = now_s1 + TAP_GAP_MS;
						n_armed = 1'b1;
						gest_c = G_TAP;
					end
				end
			end
			default: begin
				if (armed_q && !tick_gap[31]) begin
					n_armed = 1'b0;
					if (tap_cnt_q != 4'd0) begin
						done_c = 1'b1;
						total_c = tap_cnt_q;
						n_cnt = 4'd0;
						n_last = 32'd0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_active_q <= 1'b0;
			touch_handled_q <= 1'b0;
			drift_q <= 1'b0;
			armed_q <= 1'b0;
			press_x_q <= '0;
			press_y_q <= '0;
			press_time_q <= 32'd0;
			ignore_until_q <= 32'd0;
			last_tap_q <= 32'd0;
			deadline_q <= 32'd0;
			tap_cnt_q <= 4'd0;
		end else if (advance) begin
			touch_active_q <= n_active;
			touch_handled_q <= n_handled;
			drift_q <= n_drift;
			armed_q <= n_armed;
			press_x_q <= n_px;
			press_y_q <= n_py;
			press_time_q <= n_ptime;
			ignore_until_q <= n_ignore;
			last_tap_q <= n_last;
			deadline_q <= n_deadline;
			tap_cnt_q <= n_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_s2 <= gest_c;
			ok_s2 <= ok_c;
			done_s2 <= done_c;
			total_s2 <= total_c;
		end
	end

	assign out_valid = valid_s2;
	assign gesture = gesture_s2;
	assign start_ok = ok_s2;
	assign tap_done = done_s2;
	assign tap_total = total_s2;

	`TGC_ASSERT_ALWAYS(a_tap_count_limit, tap_cnt_q <= TAP_MAX)
	`TGC_ASSERT_IMPLY(a_done_range, valid_s2 && done_s2,
		(total_s2 != 4'd0) && (total_s2 <= TAP_MAX) && (gesture_s2 == G_NONE))
	`TGC_ASSERT_IMPLY(a_ok_swipe, valid_s2 && ok_s2,
		(gesture_s2 == G_LEFT) || (gesture_s2 == G_RIGHT) ||
		(gesture_s2 == G_UP) || (gesture_s2 == G_DOWN))
	`TGC_ASSERT_IMPLY(a_total_needs_done, valid_s2 && !done_s2, total_s2 == 4'd0)

endmodule
